>>> rtl/core/cmm_pkg.sv
// ----------------------------------------------------------------------------
// cmm_pkg: shared types and calendar helpers for the cron minute walker
// Holds the broken-down time record, the schedule register set, the
// register index codes and the Gregorian month-length function.
// ----------------------------------------------------------------------------
package cmm_pkg;

  localparam int unsigned MinuteW  = 6;
  localparam int unsigned HourW    = 5;
  localparam int unsigned DayW     = 5;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned YearW    = 12;
  localparam int unsigned WeekdayW = 3;

  localparam logic [MinuteW-1:0]  MinuteLast  = 6'd59;
  localparam logic [HourW-1:0]    HourLast    = 5'd23;
  localparam logic [MonthW-1:0]   MonthLast   = 4'd12;
  localparam logic [YearW-1:0]    YearFirst   = 12'd1970;
  localparam logic [YearW-1:0]    YearLast    = 12'd4095;
  localparam logic [WeekdayW-1:0] WeekdayLast = 3'd6;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 60;

  // Input beat: tdata carries the load time, tuser the function bit
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_MINUTE_MASK  = 3'd0,
    CFG_HOUR_MASK    = 3'd1,
    CFG_DAY_MASK     = 3'd2,
    CFG_MONTH_MASK   = 3'd3,
    CFG_WEEKDAY_MASK = 3'd4,
    CFG_DAY_RESTR    = 3'd5,
    CFG_WEEKDAY_RESTR = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  typedef struct packed {
    logic [WeekdayW-1:0] weekday;
    logic [YearW-1:0]    year;
    logic [MonthW-1:0]   month;
    logic [DayW-1:0]     day;
    logic [HourW-1:0]    hour;
    logic [MinuteW-1:0]  minute;
  } cal_t;

  typedef struct packed {
    logic [59:0] minute_mask;
    logic [23:0] hour_mask;
    logic [30:0] day_mask;
    logic [11:0] month_mask;
    logic [6:0]  weekday_mask;
    logic        day_restricted;
    logic        weekday_restricted;
  } sched_cfg_t;

  // Status of the beat held between the calendar and the result register
  typedef struct packed {
    logic valid;
    logic bad;
  } stage_t;

  localparam cal_t CalReset = '{
    weekday: 3'd4,
    year:    12'd1970,
    month:   4'd1,
    day:     5'd1,
    hour:    5'd0,
    minute:  6'd0
  };

  // Century years of the usable range; a century is a leap year only when
  // it is also a multiple of four hundred (its low four bits are zero then,
  // since every century here is a multiple of four and of twenty-five).
  function automatic logic is_leap(input logic [YearW-1:0] year);
    logic century;
    century = 1'b0;
    for (int k = 17; k <= 40; k++) begin
      if (year == YearW'(k * 100)) begin
        century = 1'b1;
      end
    end
    if (year[1:0] != 2'd0) begin
      return 1'b0;
    end
    if (century) begin
      return (year[3:0] == 4'd0);
    end
    return 1'b1;
  endfunction

  function automatic logic [DayW-1:0] days_in(input logic [MonthW-1:0] month,
                                              input logic [YearW-1:0]  year);
    logic [DayW-1:0] days;
    case (month) inside
      4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
      4'd2:                    days = is_leap(year) ? 5'd29 : 5'd28;
      default:                 days = 5'd31;
    endcase
    return days;
  endfunction

endpackage

>>> rtl/core/cmm_cfg_regs.sv
// ----------------------------------------------------------------------------
// cmm_cfg_regs: schedule register file
// Takes indexed writes and keeps the five masks and two restriction flags.
// ----------------------------------------------------------------------------
module cmm_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cmm_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [cmm_pkg::CfgDataW-1:0]   cfg_data_i,
  output cmm_pkg::sched_cfg_t            cfg_o
);

  cmm_pkg::sched_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cmm_pkg::cfg_idx_e'(cfg_index_i))
        cmm_pkg::CFG_MINUTE_MASK:   cfg_d.minute_mask        = cfg_data_i[59:0];
        cmm_pkg::CFG_HOUR_MASK:     cfg_d.hour_mask          = cfg_data_i[23:0];
        cmm_pkg::CFG_DAY_MASK:      cfg_d.day_mask           = cfg_data_i[30:0];
        cmm_pkg::CFG_MONTH_MASK:    cfg_d.month_mask         = cfg_data_i[11:0];
        cmm_pkg::CFG_WEEKDAY_MASK:  cfg_d.weekday_mask       = cfg_data_i[6:0];
        cmm_pkg::CFG_DAY_RESTR:     cfg_d.day_restricted     = cfg_data_i[0];
        cmm_pkg::CFG_WEEKDAY_RESTR: cfg_d.weekday_restricted = cfg_data_i[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/cmm_calendar.sv
// ----------------------------------------------------------------------------
// cmm_calendar: kept time and one-minute step
// Validates a load beat or advances the kept time by a minute on a tick,
// and flags a rejected load for the result stage.
// ----------------------------------------------------------------------------
module cmm_calendar (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic          func_i,
  input  cmm_pkg::cal_t set_i,
  output cmm_pkg::cal_t cal_o,
  output logic          bad_o
);

  cmm_pkg::cal_t cal_q, cal_d, tick_cal;
  logic          bad_q, bad_d;
  logic          load_ok;
  logic          min_wrap, hour_wrap, day_wrap, month_wrap;

  // Load checks: every field in range and the day within the month
  assign load_ok = (set_i.minute <= cmm_pkg::MinuteLast)
                && (set_i.hour <= cmm_pkg::HourLast)
                && (set_i.day != '0)
                && (set_i.month != '0)
                && (set_i.month <= cmm_pkg::MonthLast)
                && (set_i.year >= cmm_pkg::YearFirst)
                && (set_i.weekday <= cmm_pkg::WeekdayLast)
                && (set_i.day <= cmm_pkg::days_in(set_i.month, set_i.year));

  assign min_wrap   = (cal_q.minute == cmm_pkg::MinuteLast);
  assign hour_wrap  = min_wrap && (cal_q.hour == cmm_pkg::HourLast);
  assign day_wrap   = hour_wrap
                   && (cal_q.day >= cmm_pkg::days_in(cal_q.month, cal_q.year));
  assign month_wrap = day_wrap && (cal_q.month == cmm_pkg::MonthLast);

  always_comb begin
    tick_cal = cal_q;
    tick_cal.minute = min_wrap ? '0 : cal_q.minute + 6'd1;
    if (min_wrap) begin
      tick_cal.hour = hour_wrap ? '0 : cal_q.hour + 5'd1;
    end
    if (hour_wrap) begin
      tick_cal.weekday = (cal_q.weekday == cmm_pkg::WeekdayLast) ? '0
                                                                 : cal_q.weekday + 3'd1;
      tick_cal.day     = day_wrap ? 5'd1 : cal_q.day + 5'd1;
    end
    if (day_wrap) begin
      tick_cal.month = month_wrap ? 4'd1 : cal_q.month + 4'd1;
    end
    if (month_wrap) begin
      // wrap back to the first year past the top of the range
      tick_cal.year = (cal_q.year == cmm_pkg::YearLast) ? cmm_pkg::YearFirst
                                                       : cal_q.year + 12'd1;
    end
  end

  always_comb begin
    cal_d = cal_q;
    bad_d = bad_q;
    if (take_i) begin
      bad_d = 1'b0;
      if (func_i == cmm_pkg::FUNC_TICK) begin
        cal_d = tick_cal;
      end else if (load_ok) begin
        cal_d = set_i;
      end else begin
        bad_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= cmm_pkg::CalReset;
      bad_q <= 1'b0;
    end else begin
      cal_q <= cal_d;
      bad_q <= bad_d;
    end
  end

  assign cal_o = cal_q;
  assign bad_o = bad_q;

endmodule

>>> rtl/core/cmm_match_stage.sv
// ----------------------------------------------------------------------------
// cmm_match_stage: schedule test and result register
// Tests the kept time against the masks and holds the result beat until
// the downstream side takes it.
// ----------------------------------------------------------------------------
module cmm_match_stage (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cmm_pkg::sched_cfg_t          cfg_i,
  input  cmm_pkg::stage_t              stage_i,
  input  cmm_pkg::cal_t                cal_i,
  output logic                         load_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [cmm_pkg::OutDataW-1:0] out_data_o
);

  logic                         valid_q, valid_d;
  logic [cmm_pkg::OutDataW-1:0] data_q, data_d;
  logic [4:0]                   day_idx;
  logic [3:0]                   month_idx;
  logic                         dom_ok, dow_ok, day_ok, match;

  assign day_idx   = cal_i.day - 5'd1;
  assign month_idx = cal_i.month - 4'd1;

  assign dom_ok = cfg_i.day_mask[day_idx];
  assign dow_ok = cfg_i.weekday_mask[cal_i.weekday];
  // both day fields restricted: either one is enough
  assign day_ok = (cfg_i.day_restricted && cfg_i.weekday_restricted) ? (dom_ok || dow_ok)
                                                                     : (dom_ok && dow_ok);
  assign match  = cfg_i.minute_mask[cal_i.minute] && cfg_i.hour_mask[cal_i.hour]
               && cfg_i.month_mask[month_idx] && day_ok;

  assign load_o = stage_i.valid && (!valid_q || out_ready_i);

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load_o) begin
      valid_d = 1'b1;
      data_d  = {3'b000, stage_i.bad, cal_i.weekday, cal_i.year, cal_i.month,
                 cal_i.day, cal_i.hour, cal_i.minute, match};
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

>>> rtl/core/cron_minute_match_walker_unit.sv
// ----------------------------------------------------------------------------
// cron_minute_match_walker_unit: one-minute cron walker with schedule test
// Throughput: one beat per cycle while m_axis keeps up; the calendar step
// and the mask test each sit between two registers, and the result register
// frees as it drains. Each beat goes through the calendar, then the result.
// Reset: kept time goes to Thursday 1 Jan 1970 00:00, masks and flags to
// zero, no result pending. Configuration is taken in any cycle.
// ----------------------------------------------------------------------------
module cron_minute_match_walker_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // schedule registers
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cmm_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [cmm_pkg::CfgDataW-1:0]  cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // set_minute[5:0], set_hour[10:6], set_day[15:11], set_month[19:16],
  // set_year[31:20], set_weekday[34:32], zero fill [39:35]
  input  logic [cmm_pkg::InDataW-1:0]   s_axis_tdata_i,
  // func[0]
  input  logic                          s_axis_tuser_i,
  // result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // match[0], now_minute[6:1], now_hour[11:7], now_day[16:12],
  // now_month[20:17], now_year[32:21], now_weekday[35:33], bad_time[36],
  // zero fill [39:37]
  output logic [cmm_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  cmm_pkg::sched_cfg_t cfg;
  cmm_pkg::cal_t       set_cal, cal;
  cmm_pkg::stage_t     stage;
  logic                stage_valid_q, stage_valid_d;
  logic                take, bad, res_load;

  assign set_cal = s_axis_tdata_i[34:0];

  // advance when the held beat moves on or nothing is held
  assign s_axis_tready_o = !stage_valid_q || res_load;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (take) begin
      stage_valid_d = 1'b1;
    end else if (res_load) begin
      stage_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  assign stage = '{valid: stage_valid_q, bad: bad};

  cmm_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cmm_calendar u_calendar (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .func_i (s_axis_tuser_i),
    .set_i  (set_cal),
    .cal_o  (cal),
    .bad_o  (bad)
  );

  cmm_match_stage u_match_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .stage_i     (stage),
    .cal_i       (cal),
    .load_o      (res_load),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
